[rtl/bqpe_pkg.sv]
// ---------------------------------------------------------------------------
// bqpe_pkg
// Shared constants and the control struct that travels with each beat
// through the quintic Bezier evaluator pipeline.
// ---------------------------------------------------------------------------
package bqpe_pkg;

    localparam int DEGREE       = 5;
    localparam int NPTS         = DEGREE + 1;
    localparam int NAXES        = 2;
    localparam int AXIS_X       = 0;
    localparam int AXIS_Y       = 1;
    localparam int OUT_BITS     = 24;
    localparam int POINT_FRAC   = 8;
    localparam int LIMB_BITS    = 24;
    localparam int CFG_IDX_BITS = 3;

    // endpt: parameter was at or above one, result is control point 5
    typedef struct packed {
        logic valid;
        logic endpt;
    } bqpe_ctl_t;

endpackage

[rtl/bqpe_lerp_level.sv]
// ---------------------------------------------------------------------------
// bqpe_lerp_level
// One de Casteljau level: b'(i) = b(i)*2^TF + t*(b(i+1) - b(i)), exact.
// Three stages: difference, limb products, sum.
// ---------------------------------------------------------------------------
module bqpe_lerp_level #(
    parameter int W    = 16,
    parameter int N_IN = 6,
    parameter int TF   = 16
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  bqpe_pkg::bqpe_ctl_t                                  in_ctl,
    output logic                                                 in_ready,
    input  logic [TF-1:0]                                        in_t,
    input  logic [bqpe_pkg::NAXES*N_IN-1:0][W-1:0]               in_vals,
    output bqpe_pkg::bqpe_ctl_t                                  out_ctl,
    input  logic                                                 out_ready,
    output logic [TF-1:0]                                        out_t,
    output logic [bqpe_pkg::NAXES*(N_IN-1)-1:0][W+TF-1:0]        out_vals
);
    import bqpe_pkg::*;

    localparam int N_OUT  = N_IN - 1;
    localparam int NV_OUT = NAXES * N_OUT;
    localparam int DW     = W + 1;
    localparam int LB     = LIMB_BITS;
    localparam int NL     = (DW + LB - 1) / LB;
    localparam int XW     = NL * LB;
    localparam int PPW    = LB + TF + 1;
    localparam int OW     = W + TF;
    localparam int BIGW   = XW + TF + 1;

    // stage 1: differences
    logic                          v1_reg, e1_reg;
    logic [TF-1:0]                 t1_reg;
    logic [NV_OUT-1:0][W-1:0]      a1_reg, a1_next;
    logic [NV_OUT-1:0][DW-1:0]     d1_reg, d1_next;
    // stage 2: limb products
    logic                          v2_reg, e2_reg;
    logic [TF-1:0]                 t2_reg;
    logic [NV_OUT-1:0][W-1:0]      a2_reg;
    logic [NV_OUT-1:0][NL-1:0][PPW-1:0] pp2_reg, pp2_next;
    // stage 3: sums
    logic                          v3_reg, e3_reg;
    logic [TF-1:0]                 t3_reg;
    logic [NV_OUT-1:0][OW-1:0]     s3_reg, s3_next;

    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    genvar k, j;
    generate
        for (k = 0; k < NV_OUT; k++) begin : g_lane
            localparam int LO = (k / N_OUT) * N_IN + (k % N_OUT);
            logic signed [XW-1:0]   dx;
            logic [OW-1:0]          acc;
            logic signed [BIGW-1:0] ext;
            logic [BIGW-1:0]        shl;

            assign a1_next[k] = in_vals[LO];
            assign d1_next[k] = DW'($signed(in_vals[LO+1])) - DW'($signed(in_vals[LO]));

            assign dx = XW'($signed(d1_reg[k]));
            for (j = 0; j < NL; j++) begin : g_limb
                if (j < NL - 1) begin : g_low
                    assign pp2_next[k][j] = PPW'($signed({1'b0, dx[j*LB +: LB]}) *
                                                 $signed({1'b0, t1_reg}));
                end else begin : g_top
                    assign pp2_next[k][j] = PPW'($signed(dx[j*LB +: LB]) *
                                                 $signed({1'b0, t1_reg}));
                end
            end

            // exact result fits OW bits, so the sum is taken modulo 2^OW
            always_comb begin
                acc = {a2_reg[k], {TF{1'b0}}};
                ext = '0;
                shl = '0;
                for (int m = 0; m < NL; m++) begin
                    ext = BIGW'($signed(pp2_reg[k][m]));
                    shl = ext <<< (m * LB);
                    acc = acc + shl[OW-1:0];
                end
                s3_next[k] = acc;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_ctl.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_ctl.valid) begin
            e1_reg <= in_ctl.endpt;
            t1_reg <= in_t;
            a1_reg <= a1_next;
            d1_reg <= d1_next;
        end
        if (rdy2 && v1_reg) begin
            e2_reg  <= e1_reg;
            t2_reg  <= t1_reg;
            a2_reg  <= a1_reg;
            pp2_reg <= pp2_next;
        end
        if (rdy3 && v2_reg) begin
            e3_reg <= e2_reg;
            t3_reg <= t2_reg;
            s3_reg <= s3_next;
        end
    end

    assign out_ctl  = '{valid: v3_reg, endpt: e3_reg};
    assign out_t    = t3_reg;
    assign out_vals = s3_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !out_ready |=> v3_reg && $stable(s3_reg))
        else $error("level output changed while stalled");

    a_stage_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && rdy2 |=> v2_reg)
        else $error("beat lost between difference and product stages");

    a_in_take: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ctl.valid && rdy1 |=> v1_reg)
        else $error("accepted beat not captured");

endmodule

[rtl/bqpe_round.sv]
// ---------------------------------------------------------------------------
// bqpe_round
// Output stage: round half up to 8 fraction bits, endpoint select,
// saturation to 24 bits, output register.
// ---------------------------------------------------------------------------
module bqpe_round #(
    parameter int CB = 16,
    parameter int TF = 16
) (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  bqpe_pkg::bqpe_ctl_t                                    in_ctl,
    output logic                                                   in_ready,
    input  logic [bqpe_pkg::NAXES-1:0][CB+bqpe_pkg::DEGREE*TF-1:0] in_vals,
    input  logic [bqpe_pkg::NAXES-1:0][CB-1:0]                     p5,
    output logic                                                   out_valid,
    input  logic                                                   out_ready,
    output logic signed [bqpe_pkg::OUT_BITS-1:0]                   out_x,
    output logic signed [bqpe_pkg::OUT_BITS-1:0]                   out_y
);
    import bqpe_pkg::*;

    localparam int W  = CB + DEGREE * TF;
    localparam int SH = DEGREE * TF - POINT_FRAC;
    localparam int RW = W - SH;
    localparam logic [W-1:0] HALF = {{(W-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};

    logic                                   v_reg;
    logic [NAXES-1:0][OUT_BITS-1:0]         o_reg, o_next;
    logic                                   rdy;

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    genvar a;
    generate
        for (a = 0; a < NAXES; a++) begin : g_axis
            logic [W-1:0]  rnd;
            logic [RW-1:0] sel;

            assign rnd = in_vals[a] + HALF;
            assign sel = in_ctl.endpt ? {p5[a], {POINT_FRAC{1'b0}}} : rnd[W-1:SH];

            if (RW > OUT_BITS) begin : g_sat
                localparam logic [RW-1:0] MAXV =
                    {{(RW-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
                localparam logic [RW-1:0] MINV = ~MAXV;
                always_comb begin
                    if ($signed(sel) > $signed(MAXV))
                        o_next[a] = MAXV[OUT_BITS-1:0];
                    else if ($signed(sel) < $signed(MINV))
                        o_next[a] = MINV[OUT_BITS-1:0];
                    else
                        o_next[a] = sel[OUT_BITS-1:0];
                end
            end else begin : g_ext
                assign o_next[a] = OUT_BITS'($signed(sel));
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (rdy) begin
            v_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy && in_ctl.valid) begin
            o_reg <= o_next;
        end
    end

    assign out_valid = v_reg;
    assign out_x     = o_reg[AXIS_X];
    assign out_y     = o_reg[AXIS_Y];

endmodule

[rtl/bezier_quintic_point_eval.sv]
// ---------------------------------------------------------------------------
// bezier_quintic_point_eval
// Degree-5 Bezier point evaluation, exact de Casteljau in fixed point.
//
//   port group   dir   payload               handshake
//   cfg_*        in    cfg_idx, cfg_wdata    cfg_wen, no wait
//   s_*          in    s_param_t             s_valid / s_ready
//   m_*          out   m_point_x, m_point_y  m_valid / m_ready
//
// One beat per cycle sustained while m_ready is high; pipeline of five levels
// of three stages each, plus the rounding/output register.
// Each level runs one t-multiplier per lane, cut into 24-bit limbs.
// Reset clears the control points to zero and empties the pipeline.
// Stalls back up stage by stage; empty stages still fill while m_ready is low.
// ---------------------------------------------------------------------------
module bezier_quintic_point_eval #(
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [bqpe_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
    input  logic [2*COORD_BITS-1:0]               cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [T_FRAC_BITS:0]                  s_param_t,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bqpe_pkg::OUT_BITS-1:0]  m_point_x,
    output logic signed [bqpe_pkg::OUT_BITS-1:0]  m_point_y
);
    import bqpe_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int TF = T_FRAC_BITS;
    localparam int W0 = CB;
    localparam int W1 = CB + TF;
    localparam int W2 = CB + 2 * TF;
    localparam int W3 = CB + 3 * TF;
    localparam int W4 = CB + 4 * TF;
    localparam int W5 = CB + 5 * TF;

    logic [NPTS-1:0][2*CB-1:0] ctrl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (cfg_wen && (cfg_idx < CFG_IDX_BITS'(NPTS))) begin
            ctrl_reg[cfg_idx] <= cfg_wdata;
        end
    end

    // level inputs, axis-major: x points then y points
    logic [NAXES*NPTS-1:0][W0-1:0] vals0;
    always_comb begin
        for (int i = 0; i < NPTS; i++) begin
            vals0[AXIS_X*NPTS + i] = ctrl_reg[i][CB-1:0];
            vals0[AXIS_Y*NPTS + i] = ctrl_reg[i][2*CB-1:CB];
        end
    end

    // t at or above one: run with t = 0, swap in point 5 at the end
    bqpe_ctl_t     ctl0, ctl1, ctl2, ctl3, ctl4, ctl5;
    logic          rdy1, rdy2, rdy3, rdy4, rdy5;
    logic [TF-1:0] t0, t1, t2, t3, t4;

    assign ctl0 = '{valid: s_valid, endpt: s_param_t[TF]};
    assign t0   = s_param_t[TF] ? '0 : s_param_t[TF-1:0];
    assign s_ready = rdy1;

    logic [NAXES*5-1:0][W1-1:0] vals1;
    logic [NAXES*4-1:0][W2-1:0] vals2;
    logic [NAXES*3-1:0][W3-1:0] vals3;
    logic [NAXES*2-1:0][W4-1:0] vals4;
    logic [NAXES*1-1:0][W5-1:0] vals5;

    bqpe_lerp_level #(.W(W0), .N_IN(6), .TF(TF)) u_lvl1 (
        .aclk(aclk), .aresetn(aresetn),
        .in_ctl(ctl0), .in_ready(rdy1), .in_t(t0), .in_vals(vals0),
        .out_ctl(ctl1), .out_ready(rdy2), .out_t(t1), .out_vals(vals1)
    );

    bqpe_lerp_level #(.W(W1), .N_IN(5), .TF(TF)) u_lvl2 (
        .aclk(aclk), .aresetn(aresetn),
        .in_ctl(ctl1), .in_ready(rdy2), .in_t(t1), .in_vals(vals1),
        .out_ctl(ctl2), .out_ready(rdy3), .out_t(t2), .out_vals(vals2)
    );

    bqpe_lerp_level #(.W(W2), .N_IN(4), .TF(TF)) u_lvl3 (
        .aclk(aclk), .aresetn(aresetn),
        .in_ctl(ctl2), .in_ready(rdy3), .in_t(t2), .in_vals(vals2),
        .out_ctl(ctl3), .out_ready(rdy4), .out_t(t3), .out_vals(vals3)
    );

    bqpe_lerp_level #(.W(W3), .N_IN(3), .TF(TF)) u_lvl4 (
        .aclk(aclk), .aresetn(aresetn),
        .in_ctl(ctl3), .in_ready(rdy4), .in_t(t3), .in_vals(vals3),
        .out_ctl(ctl4), .out_ready(rdy5), .out_t(t4), .out_vals(vals4)
    );

    logic rdy_out;

    bqpe_lerp_level #(.W(W4), .N_IN(2), .TF(TF)) u_lvl5 (
        .aclk(aclk), .aresetn(aresetn),
        .in_ctl(ctl4), .in_ready(rdy5), .in_t(t4), .in_vals(vals4),
        .out_ctl(ctl5), .out_ready(rdy_out), .out_t(), .out_vals(vals5)
    );

    logic [NAXES-1:0][CB-1:0] p5;
    assign p5[AXIS_X] = ctrl_reg[NPTS-1][CB-1:0];
    assign p5[AXIS_Y] = ctrl_reg[NPTS-1][2*CB-1:CB];

    bqpe_round #(.CB(CB), .TF(TF)) u_round (
        .aclk(aclk), .aresetn(aresetn),
        .in_ctl(ctl5), .in_ready(rdy_out), .in_vals(vals5), .p5(p5),
        .out_valid(m_valid), .out_ready(m_ready),
        .out_x(m_point_x), .out_y(m_point_y)
    );

    a_cfg_bad_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wen && (cfg_idx >= CFG_IDX_BITS'(NPTS)) |=> $stable(ctrl_reg))
        else $error("write to unused register index altered a control point");

endmodule

[tb/sv/bezier_quintic_point_eval_checker.sv]
// ---------------------------------------------------------------------------
// bezier_quintic_point_eval_checker
// Watches the config port and both beat channels of the quintic Bezier
// evaluator. It mirrors the control points, works out each curve point
// exactly in wide integers on input acceptance, and matches it against the
// oldest point due when a result beat is accepted.
// ---------------------------------------------------------------------------
module bezier_quintic_point_eval_checker #(
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [bqpe_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
    input  logic [2*COORD_BITS-1:0]               cfg_wdata,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [T_FRAC_BITS:0]                  s_param_t,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic signed [bqpe_pkg::OUT_BITS-1:0]  m_point_x,
    input  logic signed [bqpe_pkg::OUT_BITS-1:0]  m_point_y,
    output int                                    fail_count,
    output int                                    points_due_count,
    output int                                    points_checked
);

    localparam int ACC_BITS = 128;
    localparam int BINOMIAL [bqpe_pkg::NPTS] = '{1, 5, 10, 10, 5, 1};

    typedef struct packed {
        logic signed [bqpe_pkg::OUT_BITS-1:0] x;
        logic signed [bqpe_pkg::OUT_BITS-1:0] y;
    } point_t;

    logic [2*COORD_BITS-1:0] ctrl_point [bqpe_pkg::NPTS];
    point_t                  points_due [$];
    point_t                  got_pt;
    point_t                  want_pt;
    int                      n_fail    = 0;
    int                      n_checked = 0;

    initial begin
        fail_count       = 0;
        points_due_count = 0;
        points_checked   = 0;
    end

    // divide by ONE^5, round half towards +inf, clamp to the output range
    function automatic logic signed [bqpe_pkg::OUT_BITS-1:0] round_axis(
        input logic signed [ACC_BITS-1:0] acc
    );
        logic signed [ACC_BITS-1:0] half;
        logic signed [ACC_BITS-1:0] q;
        logic signed [ACC_BITS-1:0] top_val;
        half    = 1;
        half    = half <<< (bqpe_pkg::DEGREE * T_FRAC_BITS - 1);
        q       = (acc + half) >>> (bqpe_pkg::DEGREE * T_FRAC_BITS);
        top_val = 1;
        top_val = (top_val <<< (bqpe_pkg::OUT_BITS - 1)) - 1;
        if (q > top_val) begin
            q = top_val;
        end else if (q < -top_val - 1) begin
            q = -top_val - 1;
        end
        return q[bqpe_pkg::OUT_BITS-1:0];
    endfunction

    function automatic point_t bezier_point_at(input logic [T_FRAC_BITS:0] t);
        logic signed [ACC_BITS-1:0] one;
        logic signed [ACC_BITS-1:0] tc;
        logic signed [ACC_BITS-1:0] weight;
        logic signed [ACC_BITS-1:0] cx;
        logic signed [ACC_BITS-1:0] cy;
        logic signed [ACC_BITS-1:0] acc_x;
        logic signed [ACC_BITS-1:0] acc_y;
        point_t                     p;
        one = 1;
        one = one <<< T_FRAC_BITS;
        tc  = ACC_BITS'(t);
        if (tc > one) begin
            tc = one;
        end
        acc_x = 0;
        acc_y = 0;
        for (int i = 0; i < bqpe_pkg::NPTS; i++) begin
            // Bernstein weight: binomial * t^i * (1-t)^(5-i), kept exact
            weight = ACC_BITS'(BINOMIAL[i]);
            for (int k = 0; k < bqpe_pkg::DEGREE; k++) begin
                weight = weight * ((k < i) ? tc : one - tc);
            end
            cx    = ACC_BITS'($signed(ctrl_point[i][COORD_BITS-1:0]));
            cy    = ACC_BITS'($signed(ctrl_point[i][2*COORD_BITS-1:COORD_BITS]));
            acc_x = acc_x + weight * cx * ACC_BITS'(256);
            acc_y = acc_y + weight * cy * ACC_BITS'(256);
        end
        p.x = round_axis(acc_x);
        p.y = round_axis(acc_y);
        return p;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bqpe_pkg::NPTS; i++) begin
                ctrl_point[i] = '0;
            end
            points_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                got_pt.x = m_point_x;
                got_pt.y = m_point_y;
                if (points_due.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected point beat, expected none, got (%0d, %0d)",
                             $time, $signed(got_pt.x), $signed(got_pt.y));
                end else begin
                    want_pt = points_due.pop_front();
                    n_checked++;
                    if (got_pt.x !== want_pt.x) begin
                        n_fail++;
                        $display("%0t: point_x mismatch, expected %0d, got %0d",
                                 $time, $signed(want_pt.x), $signed(got_pt.x));
                    end
                    if (got_pt.y !== want_pt.y) begin
                        n_fail++;
                        $display("%0t: point_y mismatch, expected %0d, got %0d",
                                 $time, $signed(want_pt.y), $signed(got_pt.y));
                    end
                end
            end
            if (s_valid && s_ready) begin
                points_due.push_back(bezier_point_at(s_param_t));
            end
            // spare indexes are dropped by the block
            if (cfg_wen && cfg_idx < bqpe_pkg::NPTS) begin
                ctrl_point[cfg_idx] = cfg_wdata;
            end
        end
        fail_count       <= n_fail;
        points_due_count <= points_due.size();
        points_checked   <= n_checked;
    end

endmodule

[tb/sv/bezier_quintic_point_eval_tb.sv]
// ---------------------------------------------------------------------------
// bezier_quintic_point_eval_tb
// Drives parameter beats into the quintic Bezier evaluator under a series of
// control-point settings (reset zeros, opposing extremes, all max, all min,
// random mixes), with random gaps on both channels and one long receiver
// hold-off. A side checker predicts and compares every point.
// ---------------------------------------------------------------------------
module bezier_quintic_point_eval_tb;

    localparam int COORD_BITS    = 16;
    localparam int T_FRAC_BITS   = 16;
    localparam int PARAM_W       = T_FRAC_BITS + 1;
    localparam int CFG_IDX_W     = bqpe_pkg::CFG_IDX_BITS;
    localparam int ONE           = 1 << T_FRAC_BITS;
    localparam int LATENCY       = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 250;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 125;

    localparam logic [bqpe_pkg::CFG_IDX_BITS-1:0] REG_CTRL_POINT_0 = '0;
    localparam logic [bqpe_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO     =
        CFG_IDX_W'(bqpe_pkg::NPTS);
    localparam logic [bqpe_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI     = '1;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    localparam logic [T_FRAC_BITS:0] EDGE_PARAMS [16] = '{
        17'h00000, 17'h00001, 17'h00002, 17'h000FF, 17'h07FFF, 17'h08000,
        17'h08001, 17'h0AAAA, 17'h05555, 17'h0FFFE, 17'h0FFFF, 17'h10000,
        17'h10001, 17'h18000, 17'h1FFFF, 17'h1AAAA
    };

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 cfg_wen;
    logic [bqpe_pkg::CFG_IDX_BITS-1:0]    cfg_idx;
    logic [2*COORD_BITS-1:0]              cfg_wdata;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [T_FRAC_BITS:0]                 s_param_t;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [bqpe_pkg::OUT_BITS-1:0] m_point_x;
    logic signed [bqpe_pkg::OUT_BITS-1:0] m_point_y;

    int fails;
    int outstanding;
    int checked;

    logic [2*COORD_BITS-1:0] pts [bqpe_pkg::NPTS];
    int  beats_sent    = 0;
    int  settings_used = 0;
    int  held_cycles   = 0;
    int  idle_cycles   = 0;
    int  beats_out     = 0;
    int  gap_left      = 0;
    int  hold_left     = 0;
    int  quiet_left    = 0;
    bit  held_once     = 0;
    bit  sender_quiet  = 0;

    bezier_quintic_point_eval #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_param_t (s_param_t),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_point_x (m_point_x),
        .m_point_y (m_point_y)
    );

    bezier_quintic_point_eval_checker #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wen          (cfg_wen),
        .cfg_idx          (cfg_idx),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_param_t        (s_param_t),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_point_x        (m_point_x),
        .m_point_y        (m_point_y),
        .fail_count       (fails),
        .points_due_count (outstanding),
        .points_checked   (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [T_FRAC_BITS:0] rand_param();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return PARAM_W'($urandom_range(0, ONE));
        if (r < 75) return PARAM_W'($urandom_range(0, 15));
        if (r < 85) return PARAM_W'(ONE - $urandom_range(0, 15));
        if (r < 93) return PARAM_W'($urandom_range(ONE + 1, 2 * ONE - 1));
        return PARAM_W'($urandom);
    endfunction

    task automatic put_param(input logic [T_FRAC_BITS:0] t);
        int g;
        s_valid   <= 1'b1;
        s_param_t <= t;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        g = sender_quiet ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic set_reg(input logic [bqpe_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [2*COORD_BITS-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // all six points, then junk to the spare indexes, which must not land
    task automatic load_points();
        for (int i = 0; i < bqpe_pkg::NPTS; i++) begin
            set_reg(REG_CTRL_POINT_0 + CFG_IDX_W'(i), pts[i]);
        end
        set_reg(REG_SPARE_LO, (2*COORD_BITS)'($urandom));
        set_reg(REG_SPARE_HI, (2*COORD_BITS)'($urandom));
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    // wait for every point due, then let the pipeline run dry
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_idx   <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_param_t <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // control points straight out of reset
        put_param('0);
        put_param(PARAM_W'(ONE));
        put_param(PARAM_W'(40000));
        settle();

        // neighbouring points at opposite extremes
        for (int i = 0; i < bqpe_pkg::NPTS; i++) begin
            pts[i] = (i % 2 == 0) ? {COORD_MIN, COORD_MAX} : {COORD_MAX, COORD_MIN};
        end
        load_points();
        foreach (EDGE_PARAMS[i]) put_param(EDGE_PARAMS[i]);
        repeat (3) put_param(rand_param());
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int i = 0; i < bqpe_pkg::NPTS; i++) begin
                if (p == 0)      pts[i] = {COORD_MAX, COORD_MAX};
                else if (p == 1) pts[i] = {COORD_MIN, COORD_MIN};
                else             pts[i] = {pick_coord(), pick_coord()};
            end
            load_points();
            sender_quiet = (p % 3 == 2);
            repeat (PHASE_BEATS) put_param(rand_param());
            settle();
        end

        $display("%0d parameter beats over %0d control-point settings, %0d points checked",
                 beats_sent, settings_used, checked);
        $display("receiver held off for %0d cycles with the input backed up", held_cycles);
        if (fails == 0 && outstanding == 0) begin
            $display("bezier_quintic_point_eval_tb: clean");
        end else begin
            $display("bezier_quintic_point_eval_tb: errors");
        end
        $finish;
    end

    // receiver: random gaps, quiet stretches, one long hold-off
    initial begin
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) beats_out++;
            if (!held_once && beats_out >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                held_cycles++;
                m_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (quiet_left > 0) begin
                    quiet_left--;
                end else begin
                    gap_left = gap_len();
                    if ($urandom_range(0, 49) == 0) quiet_left = $urandom_range(50, 200);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("bezier_quintic_point_eval_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
